// ===== src/assert_macros.svh =====
// Assertion macros shared by the classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define DFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge while out of reset.
`define DFC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/dfc_pkg.sv =====
// Types and constants shared by the decision forest classifier modules.
`timescale 1ns / 1ps

package dfc_pkg;

    localparam int NUM_TREES = 8;
    localparam int MAX_DEPTH = 10;
    localparam int PIXELS    = 64;
    localparam int CLASSES   = 10;

    localparam int SLOT_W   = 10;
    localparam int SLOTS    = 1 << SLOT_W;
    localparam int TREE_W   = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
    localparam int TC_W     = $clog2(NUM_TREES + 1);
    localparam int NODE_AW  = TREE_W + SLOT_W;
    localparam int NODE_W   = 17;
    localparam int PIX_AW   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int PIX_W    = 5;
    localparam int CLS_W    = $clog2(CLASSES);
    localparam int STEP_W   = $clog2(MAX_DEPTH);
    localparam int IDX_W    = (MAX_DEPTH + 1 > SLOT_W + 1) ? MAX_DEPTH + 1 : SLOT_W + 1;
    localparam int VOTE_W   = 4;
    localparam int VOTE_MAX = (1 << VOTE_W) - 1;
    localparam int CFG_W    = 4;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       leaf;
        logic [3:0] cls;
        logic [5:0] attr;
        logic [5:0] thr;
    } t_node;

    typedef struct packed {
        logic               is_pixel;
        logic               do_write;
        logic               last;
        logic [NODE_AW-1:0] node_addr;
        t_node              node;
        logic [PIX_AW-1:0]  pix_addr;
        logic [PIX_W-1:0]   pix_val;
    } t_cmd;

    typedef struct packed {
        logic [3:0] cls;
        logic [3:0] votes;
        logic       err;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NODE,
        S_EVAL,
        S_PIX,
        S_TALLY,
        S_OUT
    } t_state;

endpackage

// ===== src/dfc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dfc_front.sv =====
// Front end: accepts input transactions, decodes them and queues the commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfc_front
    import dfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [2:0]  i_tree_id,
    input  logic [9:0]  i_node_index,
    input  logic        i_node_is_leaf,
    input  logic [3:0]  i_node_class,
    input  logic [5:0]  i_node_attribute,
    input  logic [5:0]  i_node_threshold_x2,
    input  logic [5:0]  i_pixel_index,
    input  logic [4:0]  i_pixel_value,
    input  logic        i_last,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_pop
);

    t_cmd              cmd;
    logic              keep;
    logic              push;
    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    // Decode one transaction; items that change nothing are dropped here.
    always_comb begin
        cmd.is_pixel  = i_func;
        cmd.node_addr = {TREE_W'(i_tree_id), i_node_index};
        cmd.node.leaf = i_node_is_leaf;
        cmd.node.cls  = i_node_class;
        cmd.node.attr = i_node_attribute;
        cmd.node.thr  = i_node_threshold_x2;
        cmd.pix_addr  = PIX_AW'(i_pixel_index);
        cmd.pix_val   = i_pixel_value;
        cmd.last      = i_func & i_last;
        cmd.do_write  = i_func ? (int'(i_pixel_index) < PIXELS)
                               : (int'(i_tree_id) < NUM_TREES);
        keep          = cmd.do_write | cmd.last;
    end

    assign o_in_ready  = (r_count != QCNT_W'(QDEPTH));
    assign push        = i_in_valid & o_in_ready & keep;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        case ({push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    `DFC_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")
    `DFC_ASSERT(a_count_ptrs, i_clk, i_rst_n, QPTR_W'(r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0], "queue count disagrees with pointers")

endmodule

// ===== src/dfc_back.sv =====
// Back end: executes queued commands, walks the trees and tallies the votes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfc_back
    import dfc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [TC_W-1:0] i_trees,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    output t_result         o_result,
    input  logic            i_out_ready
);

    t_state             r_state, n_state;
    logic [TREE_W-1:0]  r_tree, n_tree;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [VOTE_W-1:0]  r_votes [CLASSES];
    logic [VOTE_W-1:0]  n_votes [CLASSES];
    logic               r_err, n_err;
    logic [CLS_W-1:0]   r_tally_ix, n_tally_ix;
    logic [CLS_W-1:0]   r_best, n_best;
    logic [VOTE_W-1:0]  r_best_votes, n_best_votes;
    logic               r_out_valid, n_out_valid;
    t_result            r_result, n_result;

    logic               node_we, node_re;
    logic [NODE_AW-1:0] node_raddr;
    logic [NODE_W-1:0]  node_rdata;
    t_node              node;
    logic               pix_we, pix_re;
    logic [PIX_AW-1:0]  pix_raddr;
    logic [PIX_W-1:0]   pix_rdata;
    logic [PIX_W-1:0]   pix;
    logic               go_true;
    logic [IDX_W-1:0]   next_idx;
    logic               walk_fail;
    logic               last_tree;
    logic               start;
    logic               out_free;
    logic [CLS_W-1:0]   vote_ix;
    logic [VOTE_W-1:0]  vote_rd;

    dfc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NUM_TREES * SLOTS),
        .AW    (NODE_AW)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (i_cmd.node_addr),
        .i_wdata (i_cmd.node),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    dfc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXELS),
        .AW    (PIX_AW)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (i_cmd.pix_addr),
        .i_wdata (i_cmd.pix_val),
        .i_re    (pix_re),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    // Datapath terms of the walk.
    always_comb begin
        node      = t_node'(node_rdata);
        pix       = (int'(node.attr) < PIXELS) ? pix_rdata : '0;
        go_true   = ({pix, 1'b0} <= node.thr);
        next_idx  = {r_idx[IDX_W-2:0], ~go_true};
        walk_fail = (r_step == STEP_W'(MAX_DEPTH - 1)) || (|next_idx[IDX_W-1:SLOT_W]);
        last_tree = ((TC_W'(r_tree) + TC_W'(1)) == i_trees);
        start     = (r_state == S_IDLE) && i_cmd_valid && i_cmd.is_pixel && i_cmd.last;
        out_free  = !r_out_valid || i_out_ready;
        vote_ix   = (r_state == S_EVAL) ? CLS_W'(node.cls) : r_tally_ix;
        vote_rd   = r_votes[vote_ix];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_trees == '0) ? S_TALLY : S_NODE;
                end
            end
            S_NODE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (node.leaf) begin
                    n_state = last_tree ? S_TALLY : S_NODE;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                if (walk_fail) begin
                    n_state = last_tree ? S_TALLY : S_NODE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_TALLY: begin
                if (r_tally_ix == CLS_W'(CLASSES - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and register updates.
    always_comb begin
        o_pop        = 1'b0;
        node_we      = 1'b0;
        pix_we       = 1'b0;
        node_re      = 1'b0;
        pix_re       = 1'b0;
        node_raddr   = {r_tree, SLOT_W'(1)};
        pix_raddr    = PIX_AW'(node.attr);
        n_tree       = r_tree;
        n_idx        = r_idx;
        n_step       = r_step;
        n_votes      = r_votes;
        n_err        = r_err;
        n_tally_ix   = r_tally_ix;
        n_best       = r_best;
        n_best_votes = r_best_votes;
        n_result     = r_result;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    node_we = !i_cmd.is_pixel && i_cmd.do_write;
                    pix_we  = i_cmd.is_pixel && i_cmd.do_write;
                end
                if (start) begin
                    for (int c = 0; c < CLASSES; c++) begin
                        n_votes[c] = '0;
                    end
                    n_err        = 1'b0;
                    n_tree       = '0;
                    n_idx        = IDX_W'(1);
                    n_step       = '0;
                    n_tally_ix   = '0;
                    n_best       = '0;
                    n_best_votes = '0;
                end
            end
            S_NODE: begin
                node_re = 1'b1;
            end
            S_EVAL: begin
                if (node.leaf) begin
                    if (int'(node.cls) < CLASSES) begin
                        if (vote_rd != VOTE_W'(VOTE_MAX)) begin
                            n_votes[vote_ix] = vote_rd + 1'b1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                    n_tree = r_tree + 1'b1;
                    n_idx  = IDX_W'(1);
                    n_step = '0;
                end else begin
                    pix_re = 1'b1;
                end
            end
            S_PIX: begin
                if (walk_fail) begin
                    n_err  = 1'b1;
                    n_tree = r_tree + 1'b1;
                    n_idx  = IDX_W'(1);
                    n_step = '0;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = {r_tree, next_idx[SLOT_W-1:0]};
                    n_idx      = next_idx;
                    n_step     = r_step + 1'b1;
                end
            end
            S_TALLY: begin
                if (vote_rd > r_best_votes) begin
                    n_best       = r_tally_ix;
                    n_best_votes = vote_rd;
                end
                n_tally_ix = r_tally_ix + 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_result.cls   = 4'(r_best);
                    n_result.votes = r_best_votes;
                    n_result.err   = r_err;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CLASSES; c++) begin
                r_votes[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_votes     <= n_votes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tree       <= n_tree;
        r_idx        <= n_idx;
        r_step       <= n_step;
        r_err        <= n_err;
        r_tally_ix   <= n_tally_ix;
        r_best       <= n_best;
        r_best_votes <= n_best_votes;
        r_result     <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `DFC_ASSERT(a_step_bound, i_clk, i_rst_n, (r_state == S_EVAL) |-> (int'(r_step) < MAX_DEPTH), "walk passed the depth limit")
    `DFC_ASSERT(a_idx_bound, i_clk, i_rst_n, (r_state == S_EVAL) |-> !(|r_idx[IDX_W-1:SLOT_W]), "walk index left the node table")

endmodule

// ===== src/decision_forest_classifier.sv =====
// Top level of the decision forest classifier: configuration register and wiring.
`timescale 1ns / 1ps

// Classifies a 64-pixel sample by majority vote over up to eight binary decision
// trees. A transaction with func 0 writes one node of a tree's heap-ordered table
// (root at slot 1, true child 2i, false child 2i+1); one with func 1 stores one
// pixel, and when its last flag is set, every tree below tree_count is walked, going
// to the true child when twice the pixel is at most the stored doubled threshold.
// One result transaction follows: the class with the most votes (the lower class
// wins a tie, no votes give class 0), its vote count, and an error flag that is set
// when a walk reaches no leaf within ten nodes or hits a leaf with a class above 9.
// Input transactions are taken one per cycle into a four-entry command queue
// while it has room, and the back end retires node and pixel writes at one per
// cycle while it is idle. A classification holds the back end: each voting tree
// costs a root read from the node table, each inner node one node-table read and
// one pixel-store read, and the ten class counters are scanned one per cycle. All
// the while, the queue keeps accepting until it fills. Node table and pixel store
// are not cleared at reset; walking a node or pixel that was never written gives
// an undefined result. The user must write tree_count through i_cfg_we and
// i_cfg_wdata only while the block is idle; the block does not enforce this.
// Values above eight act as eight and zero yields class 0 with no votes.

module decision_forest_classifier
    import dfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_func,
    input  logic [2:0]       i_tree_id,
    input  logic [9:0]       i_node_index,
    input  logic             i_node_is_leaf,
    input  logic [3:0]       i_node_class,
    input  logic [5:0]       i_node_attribute,
    input  logic [5:0]       i_node_threshold_x2,
    input  logic [5:0]       i_pixel_index,
    input  logic [4:0]       i_pixel_value,
    input  logic             i_last,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [3:0]       o_predicted_class,
    output logic [3:0]       o_winning_votes,
    output logic             o_walk_error
);

    logic [CFG_W-1:0] r_tree_count;
    logic [TC_W-1:0]  trees;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             pop;
    t_result          result;

    // The tree count register resets to a single voting tree.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_tree_count <= i_cfg_wdata;
        end
    end

    // Counts above the number of stored trees act as all trees.
    assign trees = (int'(r_tree_count) > NUM_TREES) ? TC_W'(NUM_TREES)
                                                    : TC_W'(r_tree_count);

    dfc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_tree_id           (i_tree_id),
        .i_node_index        (i_node_index),
        .i_node_is_leaf      (i_node_is_leaf),
        .i_node_class        (i_node_class),
        .i_node_attribute    (i_node_attribute),
        .i_node_threshold_x2 (i_node_threshold_x2),
        .i_pixel_index       (i_pixel_index),
        .i_pixel_value       (i_pixel_value),
        .i_last              (i_last),
        .o_cmd_valid         (cmd_valid),
        .o_cmd               (cmd),
        .i_pop               (pop)
    );

    dfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_trees     (trees),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_result    (result),
        .i_out_ready (i_out_ready)
    );

    assign o_predicted_class = result.cls;
    assign o_winning_votes   = result.votes;
    assign o_walk_error      = result.err;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the decision forest classifier.
`timescale 1ns / 1ps

// The testbench drives node-write and pixel transactions into the classifier and
// checks every result against its own model of the forest. A generator fills a
// queue of pending transactions ahead of time. It keeps a planning copy of the
// node tables and the sample store, so that before each closing pixel it can make
// sure that every voting tree walks only node slots and pixels that have been
// written. Where a walk would reach an unwritten slot, the generator first writes
// a random node there, so the trees grow as the run goes on. A clocked driver
// presents the queue on the input channel. A clocked monitor predicts a result
// for each accepted closing pixel and compares every result transaction, field by
// field, with the oldest prediction. Both channels idle at random, and tree_count
// is changed between phases, while the block is idle.

module testbench;
    import dfc_pkg::*;

    localparam bit FUNC_NODE  = 1'b0;
    localparam bit FUNC_PIXEL = 1'b1;
    localparam int NO_VOTE    = -1;
    localparam int PHASE_ITEMS = 190;  // transactions per tree_count setting
    localparam int SETTLE      = 24;   // cycles for queued node writes to retire
    localparam int LONG_HOLD   = 300;  // cycles the receiver holds off at times

    typedef struct {
        bit        func;
        bit [2:0]  tree;
        bit [9:0]  slot;
        t_node     node;
        bit [5:0]  pix_idx;
        bit [4:0]  pix_val;
        bit        last;
        bit        drain;  // the sender waits for every result before this one
    } t_forest_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_func = 1'b0;
    logic [2:0] i_tree_id = '0;
    logic [9:0] i_node_index = '0;
    logic       i_node_is_leaf = 1'b0;
    logic [3:0] i_node_class = '0;
    logic [5:0] i_node_attribute = '0;
    logic [5:0] i_node_threshold_x2 = '0;
    logic [5:0] i_pixel_index = '0;
    logic [4:0] i_pixel_value = '0;
    logic       i_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [3:0] o_predicted_class;
    logic [3:0] o_winning_votes;
    logic       o_walk_error;

    decision_forest_classifier dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_tree_id           (i_tree_id),
        .i_node_index        (i_node_index),
        .i_node_is_leaf      (i_node_is_leaf),
        .i_node_class        (i_node_class),
        .i_node_attribute    (i_node_attribute),
        .i_node_threshold_x2 (i_node_threshold_x2),
        .i_pixel_index       (i_pixel_index),
        .i_pixel_value       (i_pixel_value),
        .i_last              (i_last),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_predicted_class   (o_predicted_class),
        .o_winning_votes     (o_winning_votes),
        .o_walk_error        (o_walk_error)
    );

    always #2 i_clk = ~i_clk;

    // Prediction state: what the block should hold, updated at acceptance.
    t_node         forest_nodes [NUM_TREES*SLOTS];
    logic [4:0]    sample_pix [PIXELS];
    int            forest_trees = 1;
    t_result       awaited_results [$];

    // Planning state: what the block will hold once the queue so far is sent.
    t_node         plan_nodes [NUM_TREES*SLOTS];
    bit            plan_node_set [NUM_TREES*SLOTS];
    bit [4:0]      plan_pix [PIXELS];
    bit            plan_pix_set [PIXELS];
    int            plan_trees = 1;
    t_forest_item  to_send [$];
    int            items_made = 0;

    // Counters for the run summary and the verdict.
    int            mismatches = 0;
    int            nodes_taken = 0;
    int            pixels_taken = 0;
    int            results_seen = 0;
    int            error_results = 0;
    bit [15:0]     classes_seen = '0;
    int            settings_used = 1;

    bit            in_fire = 1'b0;
    int            tx_gap = 0;
    int            tx_burst = 0;
    int            rx_hold = 0;
    int            rx_burst = 0;
    int            next_long_hold = 12;

    // tree_count plan; the reset value 1 covers the directed part.
    int            tree_count_plan [8] = '{8, 0, 15, 3, 1, 6, 8, 2};

    // Walks one tree of the predicted forest. It returns the class that the tree
    // votes for, or NO_VOTE when the walk runs too deep or ends on a bad class.
    function automatic int walk_vote(int tree);
        int    slot = 1;
        int    pv;
        t_node nd;
        for (int depth = 0; depth < MAX_DEPTH; depth++) begin
            if (slot >= SLOTS)
                return NO_VOTE;
            nd = forest_nodes[tree*SLOTS + slot];
            if (nd.leaf)
                return (nd.cls < CLASSES) ? int'(nd.cls) : NO_VOTE;
            pv = (nd.attr < PIXELS) ? int'(sample_pix[nd.attr]) : 0;
            slot = (2*pv <= int'(nd.thr)) ? 2*slot : 2*slot + 1;
        end
        return NO_VOTE;
    endfunction

    // Majority vote over the trees below tree_count. The scan keeps the first
    // class that reaches the highest count, so ties go to the lower class.
    function automatic t_result classify_sample();
        int      tally [CLASSES];
        int      voters;
        int      v;
        t_result r;
        r = '0;
        voters = (forest_trees > NUM_TREES) ? NUM_TREES : forest_trees;
        foreach (tally[c])
            tally[c] = 0;
        for (int t = 0; t < voters; t++) begin
            v = walk_vote(t);
            if (v == NO_VOTE)
                r.err = 1'b1;
            else if (tally[v] < VOTE_MAX)
                tally[v]++;
        end
        for (int c = 0; c < CLASSES; c++) begin
            if (tally[c] > int'(r.votes)) begin
                r.votes = 4'(tally[c]);
                r.cls   = 4'(c);
            end
        end
        return r;
    endfunction

    function automatic t_node random_node(int leaf_pct);
        t_node n;
        n.leaf = ($urandom_range(0, 99) < leaf_pct);
        if ($urandom_range(0, 19) == 0)
            n.cls = 4'($urandom_range(10, 15));
        else if ($urandom_range(0, 1) != 0)
            n.cls = 4'($urandom_range(0, 3));
        else
            n.cls = 4'($urandom_range(0, 9));
        n.attr = 6'($urandom_range(0, 63));
        n.thr  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                             : 6'($urandom_range(0, 32));
        return n;
    endfunction

    function automatic int random_pixel_value();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                           : $urandom_range(0, 16);
    endfunction

    function automatic int draw_gap();
        int r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Queues one transaction and applies it to the planning copy. Fields that the
    // block ignores for this kind of transaction carry random values.
    task automatic enqueue(bit func, int tree, int slot, t_node nd, int idx, int val,
                           bit last_bit, bit drain);
        t_forest_item s;
        s.func    = func;
        s.tree    = 3'(tree);
        s.slot    = 10'(slot);
        s.node    = nd;
        s.pix_idx = 6'(idx);
        s.pix_val = 5'(val);
        s.last    = last_bit;
        s.drain   = drain;
        if (func == FUNC_NODE) begin
            plan_nodes[s.tree*SLOTS + s.slot]    = s.node;
            plan_node_set[s.tree*SLOTS + s.slot] = 1'b1;
        end else begin
            plan_pix[s.pix_idx]     = s.pix_val;
            plan_pix_set[s.pix_idx] = 1'b1;
        end
        to_send = {to_send, s};
        items_made++;
    endtask

    task automatic push_node(int tree, int slot, t_node nd, bit last_bit, bit drain);
        enqueue(FUNC_NODE, tree, slot, nd, $urandom_range(0, 63), $urandom_range(0, 31),
                last_bit, drain);
    endtask

    task automatic push_pixel(int idx, int val, bit last_bit, bit drain);
        enqueue(FUNC_PIXEL, $urandom_range(0, 7), $urandom_range(0, 1023),
                t_node'(NODE_W'($urandom_range(0, (1 << NODE_W) - 1))), idx, val,
                last_bit, drain);
    endtask

    // Follows every voting tree through the planning copy and writes whatever
    // node or pixel the walk would find unwritten, so no walk reads stale data.
    task automatic fill_walk_paths();
        int    voters;
        int    slot;
        t_node nd;
        voters = (plan_trees > NUM_TREES) ? NUM_TREES : plan_trees;
        for (int t = 0; t < voters; t++) begin
            slot = 1;
            for (int depth = 0; depth < MAX_DEPTH && slot < SLOTS; depth++) begin
                if (!plan_node_set[t*SLOTS + slot])
                    push_node(t, slot, random_node(25), 1'($urandom_range(0, 1)), 1'b0);
                nd = plan_nodes[t*SLOTS + slot];
                if (nd.leaf)
                    break;
                if (!plan_pix_set[nd.attr])
                    push_pixel(nd.attr, random_pixel_value(), 1'b0, 1'b0);
                slot = (2*int'(plan_pix[nd.attr]) <= int'(nd.thr)) ? 2*slot : 2*slot + 1;
            end
        end
    endtask

    // Closing pixel of a sample. Its own pixel is stored before the trees are
    // walked, so it goes into the planning copy ahead of the path check.
    task automatic close_sample(int idx, int val, bit drain);
        plan_pix[idx]     = 5'(val);
        plan_pix_set[idx] = 1'b1;
        fill_walk_paths();
        push_pixel(idx, val, 1'b1, drain);
    endtask

    // Returns once everything queued has been accepted and every predicted
    // result has arrived, plus time for trailing node writes to retire.
    task automatic wait_idle();
        while (to_send.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tree_count(int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 4'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        plan_trees = value;
        settings_used++;
    endtask

    task automatic check_field(string what, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Stimulus: reset, the directed part, then one random phase per setting.
    initial begin
        int phase_end;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A one-split tree 0 whose split sits exactly on the threshold limit.
        push_node(0, 1, '{leaf: 1'b0, cls: 4'd0, attr: 6'd63, thr: 6'd32}, 1'b0, 1'b0);
        push_node(0, 2, '{leaf: 1'b1, cls: 4'd9, attr: 6'd0, thr: 6'd0}, 1'b0, 1'b0);
        push_node(0, 3, '{leaf: 1'b1, cls: 4'd0, attr: 6'd0, thr: 6'd0}, 1'b0, 1'b0);
        // Far corner of the table with every field at its top, and a last flag
        // on a node write, which must give no result.
        push_node(7, 1023, '{leaf: 1'b1, cls: 4'd15, attr: 6'd63, thr: 6'd63},
                  1'b1, 1'b0);
        // Slot zero can be written but is never walked.
        push_node(3, 0, '{leaf: 1'b0, cls: 4'd0, attr: 6'd0, thr: 6'd0}, 1'b0, 1'b0);
        push_pixel(63, 16, 1'b0, 1'b0);
        close_sample(0, 0, 1'b0);           // 32 <= 32 takes the true branch
        close_sample(63, 17, 1'b0);         // 34 > 32 takes the false branch
        // A leaf class above nine votes nothing and flags an error.
        push_node(0, 3, '{leaf: 1'b1, cls: 4'd12, attr: 6'd0, thr: 6'd0}, 1'b0, 1'b0);
        close_sample(5, 31, 1'b0);
        // A chain of ten inner nodes down the true side runs out of depth. The
        // sender first lets every earlier result come back.
        for (int k = 0; k < MAX_DEPTH; k++)
            push_node(0, 1 << k, '{leaf: 1'b0, cls: 4'(k), attr: 6'd0, thr: 6'd63},
                      1'b0, k == 0);
        close_sample(0, 31, 1'b0);

        foreach (tree_count_plan[p]) begin
            wait_idle();
            write_tree_count(tree_count_plan[p]);
            phase_end = items_made + PHASE_ITEMS;
            while (items_made < phase_end) begin
                if ($urandom_range(0, 4) == 0) begin
                    // Stray node write, mostly near the roots where it reshapes
                    // live paths.
                    push_node($urandom_range(0, 7),
                              ($urandom_range(0, 1) != 0) ? $urandom_range(1, 31)
                                                          : $urandom_range(0, 1023),
                              random_node(40), 1'($urandom_range(0, 1)), 1'b0);
                end else begin
                    repeat ($urandom_range(0, 5))
                        push_pixel($urandom_range(0, 63), random_pixel_value(),
                                   1'b0, 1'b0);
                    close_sample($urandom_range(0, 63), random_pixel_value(),
                                 $urandom_range(0, 199) == 0);
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("summary: %0d node writes and %0d pixels sent under %0d tree_count settings",
                 nodes_taken, pixels_taken, settings_used);
        $display("summary: %0d classifications checked, %0d with walk errors, classes %b",
                 results_seen, error_results, classes_seen);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Sender: presents the queue, holds each transaction until it is accepted,
    // and leaves random gaps between transactions with occasional bursts.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (to_send.size() != 0 &&
                         !(to_send[0].drain && awaited_results.size() != 0)) begin
                i_func              <= to_send[0].func;
                i_tree_id           <= to_send[0].tree;
                i_node_index        <= to_send[0].slot;
                i_node_is_leaf      <= to_send[0].node.leaf;
                i_node_class        <= to_send[0].node.cls;
                i_node_attribute    <= to_send[0].node.attr;
                i_node_threshold_x2 <= to_send[0].node.thr;
                i_pixel_index       <= to_send[0].pix_idx;
                i_pixel_value       <= to_send[0].pix_val;
                i_last              <= to_send[0].last;
                i_in_valid          <= 1'b1;
                void'(to_send.pop_front());
                if (tx_burst > 0)
                    tx_burst--;
                else if ($urandom_range(0, 49) == 0)
                    tx_burst = $urandom_range(30, 80);
                else
                    tx_gap = draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, bursts of steady readiness, and now and then a
    // long hold-off so the block fills up and stops taking input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (results_seen >= next_long_hold) begin
            rx_hold = LONG_HOLD;
            next_long_hold += 100;
            i_out_ready <= 1'b0;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_out_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 49))
                0: begin
                    rx_burst = $urandom_range(30, 80);
                    i_out_ready <= 1'b1;
                end
                1: begin
                    rx_hold = $urandom_range(8, 40);
                    i_out_ready <= 1'b0;
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Monitor: follows register writes and accepted transactions in the model,
    // and checks every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_cfg_we)
            forest_trees = int'(i_cfg_wdata);
        if (in_fire) begin
            if (i_func == FUNC_NODE) begin
                nodes_taken++;
                forest_nodes[int'(i_tree_id)*SLOTS + int'(i_node_index)] =
                    {i_node_is_leaf, i_node_class, i_node_attribute, i_node_threshold_x2};
            end else begin
                pixels_taken++;
                sample_pix[i_pixel_index] = i_pixel_value;
                if (i_last)
                    awaited_results = {awaited_results, classify_sample()};
            end
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_walk_error === 1'b1)
                error_results++;
            if (o_predicted_class < 16)
                classes_seen[o_predicted_class] = 1'b1;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got class %0d votes %0d",
                         $time, o_predicted_class, o_winning_votes);
            end else begin
                want = awaited_results.pop_front();
                check_field("predicted_class", want.cls, o_predicted_class);
                check_field("winning_votes", want.votes, o_winning_votes);
                check_field("walk_error", {3'b000, want.err}, {3'b000, o_walk_error});
            end
        end
    end

endmodule
